>>> rtl/fsm_transition_table_lookup_unit_defines.svh
// Assertion macros used by the checker file fsmtt_chk.sv.
`ifndef FSM_TRANSITION_TABLE_LOOKUP_UNIT_DEFINES_SVH
`define FSM_TRANSITION_TABLE_LOOKUP_UNIT_DEFINES_SVH

// Checked on every rising edge outside reset.
`define FTTL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define FTTL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/fsmtt_pkg.sv
`default_nettype none
package fsmtt_pkg;

  localparam int DEF_TABLE_ROWS = 16;
  localparam int DEF_STATE_BITS = 8;

  // fixed field widths
  localparam int ROW_W = 4;
  localparam int ST_W  = 8;
  localparam int ID_W  = 16;
  localparam int DAT_W = 16;
  localparam int EXT_W = 32;
  localparam int ACT_W = 8;
  localparam int CNT_W = 5;

  // rows addressable by the row index field
  localparam int MAX_ROWS = 2 ** ROW_W;

  localparam int IN_FIELDS_W  = ROW_W + ST_W + ID_W + DAT_W + EXT_W + ST_W + ACT_W
                                + ST_W + ID_W + DAT_W + EXT_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = ST_W + ACT_W + ROW_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  // request kinds carried in in_tuser
  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  typedef struct packed {
    logic vld;
    logic lookup;
  } ctl_t;

  // outcome half of a row write, travels down to the outcome table
  typedef struct packed {
    logic [ROW_W-1:0] idx;
    logic [ST_W-1:0]  to_state;
    logic [ACT_W-1:0] action;
  } wr_out_t;

  typedef struct packed {
    logic             matched;
    logic [ROW_W-1:0] hit_idx;
    logic [ST_W-1:0]  cur_state;
  } lk_t;

endpackage
`default_nettype wire

>>> rtl/fsmtt_match.sv
`default_nettype none
module fsmtt_match #(
  parameter int TABLE_ROWS = fsmtt_pkg::DEF_TABLE_ROWS,
  parameter int STATE_BITS = fsmtt_pkg::DEF_STATE_BITS,
  localparam int NROWS = (TABLE_ROWS < fsmtt_pkg::MAX_ROWS) ? TABLE_ROWS
                                                           : fsmtt_pkg::MAX_ROWS,
  localparam int SB    = (STATE_BITS < fsmtt_pkg::ST_W) ? STATE_BITS : fsmtt_pkg::ST_W
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        adv,
  input  wire logic                        in_vld,
  input  wire logic                        in_lookup,
  input  wire logic [fsmtt_pkg::ROW_W-1:0] row_index,
  input  wire logic [fsmtt_pkg::ST_W-1:0]  row_from_state,
  input  wire logic [fsmtt_pkg::ID_W-1:0]  row_event_id,
  input  wire logic [fsmtt_pkg::DAT_W-1:0] row_event_data,
  input  wire logic [fsmtt_pkg::EXT_W-1:0] row_extra_reason,
  input  wire logic [fsmtt_pkg::ST_W-1:0]  row_to_state,
  input  wire logic [fsmtt_pkg::ACT_W-1:0] row_action,
  input  wire logic [fsmtt_pkg::ST_W-1:0]  cur_state,
  input  wire logic [fsmtt_pkg::ID_W-1:0]  ev_id,
  input  wire logic [fsmtt_pkg::DAT_W-1:0] ev_data,
  input  wire logic [fsmtt_pkg::EXT_W-1:0] ev_extra,
  input  wire logic [fsmtt_pkg::CNT_W-1:0] active_rows,
  output fsmtt_pkg::ctl_t                  s2_ctl,
  output logic [NROWS-1:0]                 s2_hit,
  output logic [fsmtt_pkg::ST_W-1:0]       s2_state,
  output fsmtt_pkg::wr_out_t               s2_wr
);

  fsmtt_pkg::ctl_t                  s1_ctl_r;
  logic [fsmtt_pkg::ST_W-1:0]       s1_state_r;
  logic [fsmtt_pkg::ID_W-1:0]       s1_id_r;
  logic [fsmtt_pkg::DAT_W-1:0]      s1_data_r;
  logic [fsmtt_pkg::EXT_W-1:0]      s1_extra_r;
  fsmtt_pkg::wr_out_t               s1_wr_r;

  logic [SB-1:0]                    key_state_r [NROWS];
  logic [fsmtt_pkg::ID_W-1:0]       key_id_r    [NROWS];
  logic [fsmtt_pkg::DAT_W-1:0]      key_data_r  [NROWS];
  logic [fsmtt_pkg::EXT_W-1:0]      key_extra_r [NROWS];

  fsmtt_pkg::ctl_t                  s2_ctl_r;
  logic [NROWS-1:0]                 s2_hit_r;
  logic [NROWS-1:0]                 hit_nxt;
  logic [fsmtt_pkg::ST_W-1:0]       s2_state_r;
  fsmtt_pkg::wr_out_t               s2_wr_r;
  logic                             key_we;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
    end else if (adv) begin
      s1_ctl_r.vld    <= in_vld;
      s1_ctl_r.lookup <= in_lookup;
    end
  end

  // writes and lookups share the key registers
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_state_r       <= in_lookup ? cur_state : row_from_state;
      s1_id_r          <= in_lookup ? ev_id     : row_event_id;
      s1_data_r        <= in_lookup ? ev_data   : row_event_data;
      s1_extra_r       <= in_lookup ? ev_extra  : row_extra_reason;
      s1_wr_r.idx      <= row_index;
      s1_wr_r.to_state <= row_to_state;
      s1_wr_r.action   <= row_action;
    end
  end

  assign key_we = adv && s1_ctl_r.vld && !s1_ctl_r.lookup;

  // key table is written at the compare stage so lookups see writes in order
  always_ff @(posedge clk) begin
    for (int r = 0; r < NROWS; r++) begin
      if (key_we && s1_wr_r.idx == fsmtt_pkg::ROW_W'(r)) begin
        key_state_r[r] <= s1_state_r[SB-1:0];
        key_id_r[r]    <= s1_id_r;
        key_data_r[r]  <= s1_data_r;
        key_extra_r[r] <= s1_extra_r;
      end
    end
  end

  always_comb begin
    for (int r = 0; r < NROWS; r++) begin
      hit_nxt[r] = s1_ctl_r.lookup
                   && (fsmtt_pkg::CNT_W'(r) < active_rows)
                   && (key_state_r[r] == s1_state_r[SB-1:0])
                   && (key_id_r[r]    == s1_id_r)
                   && (key_data_r[r]  == s1_data_r)
                   && (key_extra_r[r] == s1_extra_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_ctl_r <= '0;
    end else if (adv) begin
      s2_ctl_r <= s1_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_hit_r   <= hit_nxt;
      s2_state_r <= s1_state_r;
      s2_wr_r    <= s1_wr_r;
    end
  end

  assign s2_ctl   = s2_ctl_r;
  assign s2_hit   = s2_hit_r;
  assign s2_state = s2_state_r;
  assign s2_wr    = s2_wr_r;

endmodule
`default_nettype wire

>>> rtl/fsmtt_prio.sv
`default_nettype none
module fsmtt_prio #(
  parameter int TABLE_ROWS = fsmtt_pkg::DEF_TABLE_ROWS,
  localparam int NROWS = (TABLE_ROWS < fsmtt_pkg::MAX_ROWS) ? TABLE_ROWS
                                                           : fsmtt_pkg::MAX_ROWS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  adv,
  input  fsmtt_pkg::ctl_t            s2_ctl,
  input  wire logic [NROWS-1:0]      s2_hit,
  input  wire logic [fsmtt_pkg::ST_W-1:0] s2_state,
  input  fsmtt_pkg::wr_out_t         s2_wr,
  output fsmtt_pkg::ctl_t            s3_ctl,
  output fsmtt_pkg::lk_t             s3_lk,
  output fsmtt_pkg::wr_out_t         s3_wr
);

  fsmtt_pkg::ctl_t    s3_ctl_r;
  fsmtt_pkg::lk_t     s3_lk_r;
  fsmtt_pkg::lk_t     lk_nxt;
  fsmtt_pkg::wr_out_t s3_wr_r;

  // highest set hit wins
  always_comb begin
    lk_nxt.matched   = |s2_hit;
    lk_nxt.hit_idx   = '0;
    lk_nxt.cur_state = s2_state;
    for (int r = 0; r < NROWS; r++) begin
      if (s2_hit[r]) begin
        lk_nxt.hit_idx = fsmtt_pkg::ROW_W'(r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_ctl_r <= '0;
    end else if (adv) begin
      s3_ctl_r <= s2_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_lk_r <= lk_nxt;
      s3_wr_r <= s2_wr;
    end
  end

  assign s3_ctl = s3_ctl_r;
  assign s3_lk  = s3_lk_r;
  assign s3_wr  = s3_wr_r;

endmodule
`default_nettype wire

>>> rtl/fsmtt_outcome.sv
`default_nettype none
module fsmtt_outcome #(
  parameter int TABLE_ROWS = fsmtt_pkg::DEF_TABLE_ROWS,
  parameter int STATE_BITS = fsmtt_pkg::DEF_STATE_BITS,
  localparam int NROWS = (TABLE_ROWS < fsmtt_pkg::MAX_ROWS) ? TABLE_ROWS
                                                           : fsmtt_pkg::MAX_ROWS,
  localparam int SB    = (STATE_BITS < fsmtt_pkg::ST_W) ? STATE_BITS : fsmtt_pkg::ST_W
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        adv,
  input  fsmtt_pkg::ctl_t                  s3_ctl,
  input  fsmtt_pkg::lk_t                   s3_lk,
  input  fsmtt_pkg::wr_out_t               s3_wr,
  output logic                             out_vld,
  output logic [fsmtt_pkg::ST_W-1:0]       out_next_state,
  output logic                             out_matched,
  output logic [fsmtt_pkg::ACT_W-1:0]      out_action,
  output logic [fsmtt_pkg::ROW_W-1:0]      out_hit_row
);

  logic [SB-1:0]                  out_state_r  [NROWS];
  logic [fsmtt_pkg::ACT_W-1:0]    out_act_r    [NROWS];
  logic [SB-1:0]                  sel_state;
  logic [fsmtt_pkg::ACT_W-1:0]    sel_act;
  logic                           out_vld_r;
  logic [fsmtt_pkg::ST_W-1:0]     next_state_r;
  logic                           matched_r;
  logic [fsmtt_pkg::ACT_W-1:0]    action_r;
  logic [fsmtt_pkg::ROW_W-1:0]    hit_row_r;
  logic                           out_we;

  assign out_we = adv && s3_ctl.vld && !s3_ctl.lookup;

  // outcome table is written at its read stage, keeping row updates ordered
  always_ff @(posedge clk) begin
    for (int r = 0; r < NROWS; r++) begin
      if (out_we && s3_wr.idx == fsmtt_pkg::ROW_W'(r)) begin
        out_state_r[r] <= s3_wr.to_state[SB-1:0];
        out_act_r[r]   <= s3_wr.action;
      end
    end
  end

  always_comb begin
    sel_state = '0;
    sel_act   = '0;
    for (int r = 0; r < NROWS; r++) begin
      if (s3_lk.hit_idx == fsmtt_pkg::ROW_W'(r)) begin
        sel_state = out_state_r[r];
        sel_act   = out_act_r[r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= s3_ctl.vld && s3_ctl.lookup;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      matched_r <= s3_lk.matched;
      if (s3_lk.matched) begin
        next_state_r <= fsmtt_pkg::ST_W'(sel_state);
        action_r     <= sel_act;
        hit_row_r    <= s3_lk.hit_idx;
      end else begin
        next_state_r <= s3_lk.cur_state;
        action_r     <= '0;
        hit_row_r    <= '0;
      end
    end
  end

  assign out_vld        = out_vld_r;
  assign out_next_state = next_state_r;
  assign out_matched    = matched_r;
  assign out_action     = action_r;
  assign out_hit_row    = hit_row_r;

endmodule
`default_nettype wire

>>> rtl/fsm_transition_table_lookup_unit.sv
// Transition table lookup.
// in_*: one beat is either a row write (in_tuser = 0) or an event lookup
// (in_tuser = 1). A write stores key and outcome of one row and gives no
// output beat; a row index at or above the table size is dropped.
// out_*: one beat per lookup, in input order: next state, action, hit row,
// with the matched flag on out_tuser. Highest matching row below active_rows
// wins; on a miss the current state comes back with action and row zero.
// cfg_*: cfg_we loads active_rows; write it only while the block is idle.
// Pipeline: a lookup passes the input register, key compare, priority pick and
// the outcome read into the output register, in that order. One beat per cycle
// in either direction while out_tready does not stall the pipeline.
// Reset (rst_n low, synchronous) empties the pipeline and clears active_rows;
// table rows hold garbage until written.
// A stall on out_tready freezes the whole pipeline; in_tready drops in the
// same cycle, and nothing in flight is lost or repeated.
`default_nettype none
module fsm_transition_table_lookup_unit #(
  parameter int TABLE_ROWS = fsmtt_pkg::DEF_TABLE_ROWS,
  parameter int STATE_BITS = fsmtt_pkg::DEF_STATE_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // row_index, row_from_state, row_event_id, row_event_data, row_extra_reason,
  // row_to_state, row_action, cur_state, ev_id, ev_data, ev_extra, zero pad
  input  wire logic [fsmtt_pkg::IN_TDATA_W-1:0]  in_tdata,
  // req_type
  input  wire logic                              in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // next_state, action, hit_row, zero pad
  output logic [fsmtt_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // matched
  output logic                                   out_tuser,
  input  wire logic                              cfg_we,
  input  wire logic [fsmtt_pkg::CNT_W-1:0]       cfg_wdata
);

  localparam int O_IDX   = 0;
  localparam int O_FROM  = O_IDX  + fsmtt_pkg::ROW_W;
  localparam int O_RID   = O_FROM + fsmtt_pkg::ST_W;
  localparam int O_RDAT  = O_RID  + fsmtt_pkg::ID_W;
  localparam int O_REXT  = O_RDAT + fsmtt_pkg::DAT_W;
  localparam int O_TO    = O_REXT + fsmtt_pkg::EXT_W;
  localparam int O_ACT   = O_TO   + fsmtt_pkg::ST_W;
  localparam int O_CUR   = O_ACT  + fsmtt_pkg::ACT_W;
  localparam int O_EID   = O_CUR  + fsmtt_pkg::ST_W;
  localparam int O_EDAT  = O_EID  + fsmtt_pkg::ID_W;
  localparam int O_EEXT  = O_EDAT + fsmtt_pkg::DAT_W;
  localparam int NROWS   = (TABLE_ROWS < fsmtt_pkg::MAX_ROWS) ? TABLE_ROWS
                                                             : fsmtt_pkg::MAX_ROWS;

  logic [fsmtt_pkg::CNT_W-1:0] active_rows_r;
  logic                        adv;
  logic                        out_vld;
  fsmtt_pkg::ctl_t             s2_ctl;
  logic [NROWS-1:0]            s2_hit;
  logic [fsmtt_pkg::ST_W-1:0]  s2_state;
  fsmtt_pkg::wr_out_t          s2_wr;
  fsmtt_pkg::ctl_t             s3_ctl;
  fsmtt_pkg::lk_t              s3_lk;
  fsmtt_pkg::wr_out_t          s3_wr;
  logic [fsmtt_pkg::ST_W-1:0]  o_next_state;
  logic                        o_matched;
  logic [fsmtt_pkg::ACT_W-1:0] o_action;
  logic [fsmtt_pkg::ROW_W-1:0] o_hit_row;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_rows_r <= '0;
    end else if (cfg_we) begin
      active_rows_r <= cfg_wdata;
    end
  end

  // single pipeline enable; bubbles move with the data
  assign adv       = !out_vld || out_tready;
  assign in_tready = adv;

  fsmtt_match #(
    .TABLE_ROWS (TABLE_ROWS),
    .STATE_BITS (STATE_BITS)
  ) u_match (
    .clk              (clk),
    .rst_n            (rst_n),
    .adv              (adv),
    .in_vld           (in_tvalid),
    .in_lookup        (in_tuser == fsmtt_pkg::REQ_LOOKUP),
    .row_index        (in_tdata[O_FROM-1:O_IDX]),
    .row_from_state   (in_tdata[O_RID-1:O_FROM]),
    .row_event_id     (in_tdata[O_RDAT-1:O_RID]),
    .row_event_data   (in_tdata[O_REXT-1:O_RDAT]),
    .row_extra_reason (in_tdata[O_TO-1:O_REXT]),
    .row_to_state     (in_tdata[O_ACT-1:O_TO]),
    .row_action       (in_tdata[O_CUR-1:O_ACT]),
    .cur_state        (in_tdata[O_EID-1:O_CUR]),
    .ev_id            (in_tdata[O_EDAT-1:O_EID]),
    .ev_data          (in_tdata[O_EEXT-1:O_EDAT]),
    .ev_extra         (in_tdata[O_EEXT+fsmtt_pkg::EXT_W-1:O_EEXT]),
    .active_rows      (active_rows_r),
    .s2_ctl           (s2_ctl),
    .s2_hit           (s2_hit),
    .s2_state         (s2_state),
    .s2_wr            (s2_wr)
  );

  fsmtt_prio #(
    .TABLE_ROWS (TABLE_ROWS)
  ) u_prio (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .s2_ctl   (s2_ctl),
    .s2_hit   (s2_hit),
    .s2_state (s2_state),
    .s2_wr    (s2_wr),
    .s3_ctl   (s3_ctl),
    .s3_lk    (s3_lk),
    .s3_wr    (s3_wr)
  );

  fsmtt_outcome #(
    .TABLE_ROWS (TABLE_ROWS),
    .STATE_BITS (STATE_BITS)
  ) u_outcome (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (adv),
    .s3_ctl         (s3_ctl),
    .s3_lk          (s3_lk),
    .s3_wr          (s3_wr),
    .out_vld        (out_vld),
    .out_next_state (o_next_state),
    .out_matched    (o_matched),
    .out_action     (o_action),
    .out_hit_row    (o_hit_row)
  );

  assign out_tvalid = out_vld;
  assign out_tuser  = o_matched;
  assign out_tdata  = {{fsmtt_pkg::OUT_PAD_W{1'b0}}, o_hit_row, o_action, o_next_state};

endmodule
`default_nettype wire

>>> rtl/fsmtt_chk.sv
`default_nettype none
`include "fsm_transition_table_lookup_unit_defines.svh"
module fsmtt_chk (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_tready,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [fsmtt_pkg::OUT_TDATA_W-1:0] out_tdata,
  input wire logic                              out_tuser
);

  localparam int ACT_LO = fsmtt_pkg::ST_W;
  localparam int ROW_HI = fsmtt_pkg::OUT_FIELDS_W - 1;

  // a held result beat must not change
  `FTTL_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "output beat changed while stalled")

  // a miss carries no action and row zero
  `FTTL_ASSERT(a_miss_zero, out_tvalid && !out_tuser |-> out_tdata[ROW_HI:ACT_LO] == '0, "miss beat with nonzero action or row")

  // pipeline only back-pressures when a result is waiting
  `FTTL_ASSERT(a_ready_free, !out_tvalid |-> in_tready, "input stalled with empty output")

  // reset drains the pipeline
  `FTTL_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_tvalid, "output valid right after reset")

endmodule

bind fsm_transition_table_lookup_unit fsmtt_chk u_chk (.*);
`default_nettype wire
